@@ src/mlprti_pkg.sv @@
// Shared types, constants and fixed-point helpers for the MLP train/infer block.
// Used by every module under src; depends on nothing.
`default_nettype none
package mlprti_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_LAYERS_DEF = 3;
    localparam int DATA_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam int LR_WIDTH       = 17;
    localparam int LAYERS_WIDTH   = 2;
    localparam int SIZE_WIDTH     = 5;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 17;

    localparam logic [LR_WIDTH-1:0]     LR_RESET     = 17'd66;
    localparam logic [LAYERS_WIDTH-1:0] LAYERS_RESET = 2'd2;
    localparam logic [SIZE_WIDTH-1:0]   SIZE_RESET   = 5'd16;
    localparam int                      NET_LAYERS_MAX = 3;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LEARNING_RATE = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_WEIGHT_LAYERS = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_INPUT_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_HIDDEN_ONE    = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_HIDDEN_TWO    = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_OUTPUT_THREE  = 3'd5;

    localparam logic [2:0] OP_LOAD_WEIGHT = 3'd0;
    localparam logic [2:0] OP_LOAD_BIAS   = 3'd1;
    localparam logic [2:0] OP_INPUT       = 3'd2;
    localparam logic [2:0] OP_TARGET      = 3'd3;
    localparam logic [2:0] OP_PREDICT     = 3'd4;
    localparam logic [2:0] OP_FIT         = 3'd5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef enum logic [2:0] {
        CMD_WEIGHT  = 3'd0,
        CMD_BIAS    = 3'd1,
        CMD_INPUT   = 3'd2,
        CMD_TARGET  = 3'd3,
        CMD_PREDICT = 3'd4,
        CMD_FIT     = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  layer;
        logic [3:0]  row;
        logic [3:0]  col;
        data_t       value;
    } cmd_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic data_t sat_add(input data_t a, input data_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic data_t sat_sub(input data_t a, input data_t b);
        logic signed [DATA_WIDTH:0] s;
        s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return s[DATA_WIDTH] ? DATA_MIN : DATA_MAX;
        end
        return s[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] magnitude(input data_t a);
        logic [DATA_WIDTH-1:0] u;
        u = a;
        return a[DATA_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // round half away from zero on the magnitude, then saturate and apply sign
    function automatic data_t round_product(input logic [2*DATA_WIDTH-1:0] prod,
                                            input logic neg);
        logic [2*DATA_WIDTH:0] sum;
        logic [2*DATA_WIDTH:0] q;
        logic [2*DATA_WIDTH:0] lim;
        logic [DATA_WIDTH-1:0] res;
        sum = {1'b0, prod} + ((2*DATA_WIDTH+1)'(1) << (FRAC_BITS-1));
        q   = sum >> FRAC_BITS;
        lim = ((2*DATA_WIDTH+1)'(1) << (DATA_WIDTH-1));
        if (!neg) begin
            lim = lim - 1'b1;
        end
        if (q > lim) begin
            q = lim;
        end
        res = q[DATA_WIDTH-1:0];
        return neg ? data_t'(~res + 1'b1) : data_t'(res);
    endfunction

endpackage
`default_nettype wire

@@ src/mlp_relu_train_infer_top.sv @@
// Top level of the MLP train/infer block: front end, command queue and compute engine.
// Depends on mlprti_pkg, mlprti_front, mlprti_queue and mlprti_core.
//
// Fully connected ReLU network in Q16.16 with one shared multiplier. Loads are buffered
// by a small command queue, so the input side keeps flowing while a pass runs, until the
// queue fills. Predict runs the forward pass, then sends out the output results one by
// one. Fit runs the forward pass, the error passes for every output and every neuron,
// backpropagation through every layer above the first, and then the update of every
// weight and bias. The single read port of the weight memory and the shared
// multiply/round path set the pace of these steps.
`default_nettype none
module mlp_relu_train_infer_top
    import mlprti_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // opcode[2:0], layer_sel[4:3], row_sel[8:5], col_sel[12:9], data_value[44:13]
    input  wire logic [47:0]               s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // out_index[3:0], out_value[35:4]
    output logic [39:0]                    m_tdata,
    output logic                           m_tlast
);

    cmd_t       push_cmd;
    logic       push_valid;
    logic       q_full;
    cmd_t       pop_cmd;
    logic       pop_valid;
    logic       pop;
    logic [3:0] out_index;
    data_t      out_value;

    mlprti_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    mlprti_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    mlprti_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (pop_valid),
        .q_cmd      (pop_cmd),
        .q_pop      (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_index    (out_index),
        .m_value    (out_value),
        .m_last     (m_tlast)
    );

    assign m_tdata = {4'b0000, out_value, out_index};

endmodule
`default_nettype wire

@@ src/mlprti_front.sv @@
// Input front end: takes stream transfers, decodes the opcode, drops loads with
// bad addresses and unused opcodes, and pushes commands into the queue. Uses mlprti_pkg.
`default_nettype none
module mlprti_front
    import mlprti_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[2:0], layer_sel[4:3], row_sel[8:5], col_sel[12:9], data_value[44:13]
    input  wire logic [47:0] s_tdata,
    input  wire logic        q_full,
    output logic             push_valid,
    output cmd_t             push_cmd
);

    logic [2:0] opcode;
    logic       lay_ok;
    logic       row_ok;
    logic       col_ok;
    logic       keep;

    assign opcode = s_tdata[2:0];
    assign lay_ok = int'(s_tdata[4:3]) < MAX_LAYERS;
    assign row_ok = int'(s_tdata[8:5]) < MAX_WIDTH;
    assign col_ok = int'(s_tdata[12:9]) < MAX_WIDTH;

    always_comb begin
        push_cmd.layer = s_tdata[4:3];
        push_cmd.row   = s_tdata[8:5];
        push_cmd.col   = s_tdata[12:9];
        push_cmd.value = s_tdata[44:13];
        push_cmd.kind  = CMD_PREDICT;
        keep           = 1'b0;
        unique case (opcode)
            OP_LOAD_WEIGHT: begin
                push_cmd.kind = CMD_WEIGHT;
                keep          = lay_ok && row_ok && col_ok;
            end
            OP_LOAD_BIAS: begin
                push_cmd.kind = CMD_BIAS;
                keep          = lay_ok && row_ok;
            end
            OP_INPUT: begin
                push_cmd.kind = CMD_INPUT;
                keep          = row_ok;
            end
            OP_TARGET: begin
                push_cmd.kind = CMD_TARGET;
                keep          = row_ok;
            end
            OP_PREDICT: begin
                push_cmd.kind = CMD_PREDICT;
                keep          = 1'b1;
            end
            OP_FIT: begin
                push_cmd.kind = CMD_FIT;
                keep          = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready   = !q_full;
    assign push_valid = s_tvalid && !q_full && keep;

endmodule
`default_nettype wire

@@ src/mlprti_queue.sv @@
// Short command queue between the front end and the compute engine.
// Uses mlprti_pkg for the command type and depth.
`default_nettype none
module mlprti_queue
    import mlprti_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            slot_mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = int'(count_reg) == QUEUE_DEPTH;
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = slot_mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = NW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = NW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ src/mlprti_core.sv @@
// Compute engine: configuration registers, weight/bias/activation memories,
// one shared multiplier, and the sequencer for loads, predict and fit. Uses mlprti_pkg.
`default_nettype none
module mlprti_core
    import mlprti_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  wire logic                      q_valid,
    input  wire cmd_t                      q_cmd,
    output logic                           q_pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [3:0]                     m_index,
    output data_t                          m_value,
    output logic                           m_last
);

    localparam int MW     = MAX_WIDTH;
    localparam int CW     = $clog2(MW);
    localparam int NW     = $clog2(MW + 1);
    localparam int LCW    = $clog2(MAX_LAYERS + 1);
    localparam int WDEPTH = MAX_LAYERS * MW * MW;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int BDEPTH = MAX_LAYERS * MW;
    localparam int BAW    = $clog2(BDEPTH);
    localparam int ADEPTH = (MAX_LAYERS + 1) * MW;
    localparam int AAW    = $clog2(ADEPTH);

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1 << 0,
        S_FRD   = 26'd1 << 1,
        S_FMUL  = 26'd1 << 2,
        S_FRND  = 26'd1 << 3,
        S_FACC  = 26'd1 << 4,
        S_FBIAS = 26'd1 << 5,
        S_ORD   = 26'd1 << 6,
        S_OUT   = 26'd1 << 7,
        S_ERD   = 26'd1 << 8,
        S_EWR   = 26'd1 << 9,
        S_DRD   = 26'd1 << 10,
        S_DWR   = 26'd1 << 11,
        S_BRD   = 26'd1 << 12,
        S_BMUL  = 26'd1 << 13,
        S_BRND  = 26'd1 << 14,
        S_BACC  = 26'd1 << 15,
        S_URD   = 26'd1 << 16,
        S_UMUL1 = 26'd1 << 17,
        S_URND1 = 26'd1 << 18,
        S_UMUL2 = 26'd1 << 19,
        S_URND2 = 26'd1 << 20,
        S_UWR   = 26'd1 << 21,
        S_VRD   = 26'd1 << 22,
        S_VMUL  = 26'd1 << 23,
        S_VRND  = 26'd1 << 24,
        S_VWR   = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next;

    logic [LR_WIDTH-1:0]     lr_reg;
    logic [LAYERS_WIDTH-1:0] layers_reg;
    logic [SIZE_WIDTH-1:0]   size_reg [4];

    logic [LCW-1:0] lay_reg, lay_next;
    logic [CW-1:0]  r_reg,   r_next;
    logic [CW-1:0]  c_reg,   c_next;
    data_t          acc_reg, acc_next;
    logic           fit_reg, fit_next;

    logic [LCW-1:0] nl;
    logic [LCW-1:0] lay_up;
    logic [NW-1:0]  nin;
    logic [NW-1:0]  nout;
    logic [NW-1:0]  n_net;
    logic           hidden;
    logic           r_last;
    logic           c_last;
    logic           lay_last;

    data_t                   w_mem [WDEPTH];
    data_t                   b_mem [BDEPTH];
    logic [BDEPTH-1:0]       b_vld_reg;
    data_t                   a_mem [ADEPTH];
    data_t                   t_mem [MW];
    data_t                   e_mem [BDEPTH];
    data_t                   s_mem [MW];

    logic [WAW-1:0] w_addr;
    logic [BAW-1:0] b_addr;
    logic [BAW-1:0] e_addr;
    logic [AAW-1:0] a_raddr;
    logic [AAW-1:0] a_waddr;
    logic [LCW-1:0] a_row;
    logic [CW-1:0]  a_idx;
    logic [CW-1:0]  t_addr;
    logic [CW-1:0]  s_waddr;

    logic  w_we, b_we, a_we, t_we, e_we, s_we;
    data_t w_wdata, b_wdata, a_wdata, e_wdata, s_wdata;

    data_t w_rd, b_rd, a_rd, t_rd, e_rd, s_rd;
    logic  b_rd_vld;
    data_t bias_val;

    data_t                   mul_a, mul_b;
    logic [2*DATA_WIDTH-1:0] prod_reg;
    logic                    neg_reg;
    data_t                   rnd_reg;
    data_t                   relu_in;

    logic out_load;

    function automatic logic [NW-1:0] clamp_size(input logic [SIZE_WIDTH-1:0] v);
        if (v == '0) begin
            return NW'(1);
        end
        if (int'(v) > MW) begin
            return NW'(MW);
        end
        return NW'(v);
    endfunction

    function automatic logic [SIZE_WIDTH-1:0] size_of(input logic [LCW-1:0] k,
                                                      input logic [SIZE_WIDTH-1:0] s0,
                                                      input logic [SIZE_WIDTH-1:0] s1,
                                                      input logic [SIZE_WIDTH-1:0] s2,
                                                      input logic [SIZE_WIDTH-1:0] s3);
        if (int'(k) == 0) begin
            return s0;
        end
        if (int'(k) == 1) begin
            return s1;
        end
        if (int'(k) == 2) begin
            return s2;
        end
        return s3;
    endfunction

    always_comb begin
        int v;
        v = (layers_reg == '0) ? 1 : int'(layers_reg);
        if (v > NET_LAYERS_MAX) begin
            v = NET_LAYERS_MAX;
        end
        if (v > MAX_LAYERS) begin
            v = MAX_LAYERS;
        end
        nl = LCW'(v);
    end

    assign lay_up   = LCW'(lay_reg + 1'b1);
    assign nin      = clamp_size(size_of(lay_reg, size_reg[0], size_reg[1], size_reg[2],
                                         size_reg[3]));
    assign nout     = clamp_size(size_of(lay_up, size_reg[0], size_reg[1], size_reg[2],
                                         size_reg[3]));
    assign n_net    = clamp_size(size_of(nl, size_reg[0], size_reg[1], size_reg[2],
                                         size_reg[3]));
    assign hidden   = int'(lay_reg) + 1 < int'(nl);
    assign c_last   = int'(c_reg) + 1 == int'(nin);
    assign r_last   = (state_reg == S_OUT || state_reg == S_EWR) ?
                      (int'(r_reg) + 1 == int'(n_net)) : (int'(r_reg) + 1 == int'(nout));
    assign lay_last = int'(lay_reg) + 1 == int'(nl);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg      <= LR_RESET;
            layers_reg  <= LAYERS_RESET;
            size_reg[0] <= SIZE_RESET;
            size_reg[1] <= SIZE_RESET;
            size_reg[2] <= SIZE_RESET;
            size_reg[3] <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LEARNING_RATE: lr_reg      <= cfg_wdata[LR_WIDTH-1:0];
                REG_WEIGHT_LAYERS: layers_reg  <= cfg_wdata[LAYERS_WIDTH-1:0];
                REG_INPUT_WIDTH:   size_reg[0] <= cfg_wdata[SIZE_WIDTH-1:0];
                REG_HIDDEN_ONE:    size_reg[1] <= cfg_wdata[SIZE_WIDTH-1:0];
                REG_HIDDEN_TWO:    size_reg[2] <= cfg_wdata[SIZE_WIDTH-1:0];
                REG_OUTPUT_THREE:  size_reg[3] <= cfg_wdata[SIZE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_addr  = WAW'((int'(lay_reg) * MW + int'(r_reg)) * MW + int'(c_reg));
        b_addr  = BAW'(int'(lay_reg) * MW + int'(r_reg));
        a_waddr = AAW'(int'(lay_up) * MW + int'(r_reg));
        t_addr  = r_reg;
        if (state_reg == S_IDLE) begin
            w_addr  = WAW'((int'(q_cmd.layer) * MW + int'(q_cmd.row)) * MW + int'(q_cmd.col));
            b_addr  = BAW'(int'(q_cmd.layer) * MW + int'(q_cmd.row));
            a_waddr = AAW'(q_cmd.row);
            t_addr  = CW'(q_cmd.row);
        end
    end

    assign e_addr = BAW'(int'(lay_reg) * MW + int'(r_reg));

    always_comb begin
        a_row = lay_reg;
        a_idx = c_reg;
        if (state_reg == S_ORD || state_reg == S_OUT || state_reg == S_ERD ||
            state_reg == S_EWR) begin
            a_row = nl;
            a_idx = r_reg;
        end else if (state_reg == S_DRD || state_reg == S_DWR) begin
            a_row = lay_up;
            a_idx = r_reg;
        end
    end

    assign a_raddr  = AAW'(int'(a_row) * MW + int'(a_idx));
    assign bias_val = b_rd_vld ? b_rd : '0;
    assign relu_in  = sat_add(acc_reg, bias_val);

    always_comb begin
        state_next = state_reg;
        lay_next   = lay_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        fit_next   = fit_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        w_we       = 1'b0;
        b_we       = 1'b0;
        a_we       = 1'b0;
        t_we       = 1'b0;
        e_we       = 1'b0;
        s_we       = 1'b0;
        w_wdata    = q_cmd.value;
        b_wdata    = q_cmd.value;
        a_wdata    = q_cmd.value;
        e_wdata    = s_rd;
        s_wdata    = acc_next;
        s_waddr    = r_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.kind) inside
                        CMD_WEIGHT: w_we = 1'b1;
                        CMD_BIAS:   b_we = 1'b1;
                        CMD_INPUT:  a_we = 1'b1;
                        CMD_TARGET: t_we = 1'b1;
                        CMD_PREDICT, CMD_FIT: begin
                            fit_next   = q_cmd.kind == CMD_FIT;
                            lay_next   = '0;
                            r_next     = '0;
                            c_next     = '0;
                            acc_next   = '0;
                            state_next = S_FRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_FRD:  state_next = S_FMUL;
            S_FMUL: state_next = S_FRND;
            S_FRND: state_next = S_FACC;
            S_FACC: begin
                acc_next = sat_add(acc_reg, rnd_reg);
                if (c_last) begin
                    state_next = S_FBIAS;
                end else begin
                    c_next     = CW'(c_reg + 1'b1);
                    state_next = S_FRD;
                end
            end
            S_FBIAS: begin
                a_we     = 1'b1;
                a_wdata  = (hidden && relu_in[DATA_WIDTH-1]) ? '0 : relu_in;
                acc_next = '0;
                c_next   = '0;
                if (r_last) begin
                    r_next = '0;
                    if (lay_last) begin
                        state_next = fit_reg ? S_ERD : S_ORD;
                    end else begin
                        lay_next   = lay_up;
                        state_next = S_FRD;
                    end
                end else begin
                    r_next     = CW'(r_reg + 1'b1);
                    state_next = S_FRD;
                end
            end
            S_ORD: state_next = S_OUT;
            S_OUT: begin
                if (!m_valid || m_ready) begin
                    out_load = 1'b1;
                    if (r_last) begin
                        r_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        r_next     = CW'(r_reg + 1'b1);
                        state_next = S_ORD;
                    end
                end
            end
            S_ERD: state_next = S_EWR;
            S_EWR: begin
                s_we    = 1'b1;
                s_wdata = sat_sub(a_rd, t_rd);
                if (r_last) begin
                    r_next     = '0;
                    lay_next   = LCW'(nl - 1'b1);
                    state_next = S_DRD;
                end else begin
                    r_next     = CW'(r_reg + 1'b1);
                    state_next = S_ERD;
                end
            end
            S_DRD: state_next = S_DWR;
            S_DWR: begin
                e_we    = 1'b1;
                e_wdata = (hidden && (a_rd[DATA_WIDTH-1] || a_rd == '0)) ? '0 : s_rd;
                if (r_last) begin
                    r_next = '0;
                    c_next = '0;
                    if (lay_reg == '0) begin
                        state_next = S_URD;
                    end else begin
                        acc_next   = '0;
                        state_next = S_BRD;
                    end
                end else begin
                    r_next     = CW'(r_reg + 1'b1);
                    state_next = S_DRD;
                end
            end
            S_BRD:  state_next = S_BMUL;
            S_BMUL: state_next = S_BRND;
            S_BRND: state_next = S_BACC;
            S_BACC: begin
                acc_next = sat_add(acc_reg, rnd_reg);
                if (r_last) begin
                    s_we     = 1'b1;
                    s_waddr  = c_reg;
                    s_wdata  = acc_next;
                    acc_next = '0;
                    r_next   = '0;
                    if (c_last) begin
                        c_next     = '0;
                        lay_next   = LCW'(lay_reg - 1'b1);
                        state_next = S_DRD;
                    end else begin
                        c_next     = CW'(c_reg + 1'b1);
                        state_next = S_BRD;
                    end
                end else begin
                    r_next     = CW'(r_reg + 1'b1);
                    state_next = S_BRD;
                end
            end
            S_URD:   state_next = S_UMUL1;
            S_UMUL1: state_next = S_URND1;
            S_URND1: state_next = S_UMUL2;
            S_UMUL2: state_next = S_URND2;
            S_URND2: state_next = S_UWR;
            S_UWR: begin
                w_we    = 1'b1;
                w_wdata = sat_sub(w_rd, rnd_reg);
                if (c_last) begin
                    c_next     = '0;
                    state_next = S_VRD;
                end else begin
                    c_next     = CW'(c_reg + 1'b1);
                    state_next = S_URD;
                end
            end
            S_VRD:  state_next = S_VMUL;
            S_VMUL: state_next = S_VRND;
            S_VRND: state_next = S_VWR;
            S_VWR: begin
                b_we    = 1'b1;
                b_wdata = sat_sub(bias_val, rnd_reg);
                if (r_last) begin
                    r_next = '0;
                    if (lay_last) begin
                        state_next = S_IDLE;
                    end else begin
                        lay_next   = lay_up;
                        state_next = S_URD;
                    end
                end else begin
                    r_next     = CW'(r_reg + 1'b1);
                    state_next = S_URD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lay_reg   <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            acc_reg   <= '0;
            fit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            lay_reg   <= lay_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            acc_reg   <= acc_next;
            fit_reg   <= fit_next;
        end
    end

    always_comb begin
        mul_a = w_rd;
        mul_b = a_rd;
        case (state_reg)
            S_BMUL: begin
                mul_b = e_rd;
            end
            S_UMUL1: begin
                mul_a = e_rd;
                mul_b = a_rd;
            end
            S_UMUL2: begin
                mul_a = data_t'({{(DATA_WIDTH-LR_WIDTH){1'b0}}, lr_reg});
                mul_b = rnd_reg;
            end
            S_VMUL: begin
                mul_a = data_t'({{(DATA_WIDTH-LR_WIDTH){1'b0}}, lr_reg});
                mul_b = e_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= magnitude(mul_a) * magnitude(mul_b);
        neg_reg  <= mul_a[DATA_WIDTH-1] ^ mul_b[DATA_WIDTH-1];
        rnd_reg  <= round_product(prod_reg, neg_reg);
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[w_addr] <= w_wdata;
        end
        w_rd <= w_mem[w_addr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_addr] <= b_wdata;
        end
        b_rd     <= b_mem[b_addr];
        b_rd_vld <= b_vld_reg[b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= '0;
        end else if (b_we) begin
            b_vld_reg[b_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rd <= a_mem[a_raddr];
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            t_mem[t_addr] <= q_cmd.value;
        end
        t_rd <= t_mem[t_addr];
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            e_mem[e_addr] <= e_wdata;
        end
        e_rd <= e_mem[e_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rd <= s_mem[r_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_index <= 4'(r_reg);
            m_value <= a_rd;
            m_last  <= r_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_acc_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FACC) |-> (int'(c_reg) < int'(nin)))
        else $error("column counter past layer input size");

    a_weight_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        w_we |-> (state_reg == S_IDLE || state_reg == S_UWR))
        else $error("weight written outside load or update");

    a_out_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output step");

    a_layer_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FBIAS) |-> (int'(lay_reg) < int'(nl)))
        else $error("layer counter past layer count");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_IDLE && q_valid))
        else $error("queue popped while busy or empty");
`endif

endmodule
`default_nettype wire
